>>> hdl/ofrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofrb_pkg
// Request codes, field widths and controller state type of the overwriting
// frame ring buffer.
// ----------------------------------------------------------------------------
package ofrb_pkg;

   localparam int SampleWidth = 64;
   localparam int PortChannels = 4;
   localparam int CountWidth = 5;
   localparam int ReqTypeWidth = 2;

   // req_tdata: sample_0..sample_3, read_limit, zero fill to whole bytes
   localparam int ReqDataWidth = 264;
   // rsp_tdata: frame_0..frame_3, returned_count, stored_count, zero fill
   localparam int RspDataWidth = 272;

   typedef logic [ReqTypeWidth-1:0] req_code_type;

   localparam req_code_type REQ_PUSH  = 2'd0;
   localparam req_code_type REQ_DRAIN = 2'd1;
   localparam req_code_type REQ_PEEK  = 2'd2;
   localparam req_code_type REQ_NONE  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_BURST = 2'b10
   } state_type;

endpackage

>>> hdl/overwriting_frame_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_frame_ring_buffer
// Ring of sample frames that drops the oldest frame when full, with drain
// and peek reads that stream the selected frames out one per word.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per word: push a frame, drain the oldest
//   frames or peek the newest ones (up to the read limit). rsp_* returns the
//   results: one word for a push, an empty read or an unused code, and one
//   word per frame for a drain or peek, with tlast on the final word.
//   Every result word reports the frame count held after the request.
//   A push or empty read puts its result word in the output register at
//   the accepting edge. A drain or peek first sets up the burst, then
//   moves one frame per cycle, while the receiver does not stall, out of
//   the single registered read port of the frame memory. Loading the final
//   word ends the burst; the next request waits for a free output register.
//   When the receiver stalls, the output register holds its word, the
//   memory read data register holds the next frame and no further read is
//   issued until the output register frees up.
//   Reset clears the indices, count and control state at once; the frame
//   memory is not cleared, since only held frames are ever read.
// ----------------------------------------------------------------------------
module overwriting_frame_ring_buffer #(
   parameter int DEPTH = 32,
   parameter int CHANNELS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [255:0] sample_0..sample_3 (64 bits each), [260:256] read_limit, zeros
   input  logic [ofrb_pkg::ReqDataWidth-1:0]    req_tdata,
   // [1:0] req_type
   input  logic [ofrb_pkg::ReqTypeWidth-1:0]    req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [255:0] frame_0..frame_3, [260:256] returned_count,
   // [265:261] stored_count, zeros
   output logic [ofrb_pkg::RspDataWidth-1:0]    rsp_tdata,
   // [0] frame_valid
   output logic [0:0]                           rsp_tuser,
   // is_last
   output logic                                 rsp_tlast
);

   import ofrb_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MW = (IW > CountWidth) ? IW : CountWidth;
   localparam int EW = CHANNELS * SampleWidth;
   localparam int PW = ((CHANNELS > PortChannels) ? CHANNELS : PortChannels) * SampleWidth;
   localparam int PortBits = PortChannels * SampleWidth;
   localparam logic [IW-1:0] LastIndex = IW'(DEPTH - 1);
   localparam logic [IW:0] DepthWide = (IW + 1)'(DEPTH);

   // Frame memory, one entry per frame
   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rdata_ff;

   state_type state_ff, state_in;
   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] count_ff, count_in;
   logic [IW-1:0] rd_addr_ff, rd_addr_in;
   logic [CountWidth-1:0] remain_ff, remain_in;
   logic [CountWidth-1:0] nret_ff, nret_in;
   logic rd_pend_ff, rd_pend_in;

   logic out_valid_ff, out_valid_in;
   logic [PortBits-1:0] out_frame_ff, out_frame_in;
   logic out_fvalid_ff, out_fvalid_in;
   logic out_last_ff, out_last_in;
   logic [CountWidth-1:0] out_nret_ff, out_nret_in;
   logic [CountWidth-1:0] out_stored_ff, out_stored_in;

   req_code_type req_code;
   logic [CountWidth-1:0] read_limit;
   logic [CountWidth-1:0] n_take;
   logic [PW-1:0] wdata_pad;
   logic [EW-1:0] wdata;
   logic [PW-1:0] rdata_pad;
   logic [PortBits-1:0] rd_frame;
   logic [IW-1:0] wr_next;
   logic [IW-1:0] rd_next;
   logic [IW:0] drain_sum;
   logic [IW:0] peek_sum;
   logic out_load, req_fire, consume, issue, wr_en;

   assign req_code   = req_tuser;
   assign read_limit = req_tdata[PortBits +: CountWidth];

   // Pad the pushed samples to the stored width, zeros beyond the ports
   assign wdata_pad = PW'(req_tdata[PortBits-1:0]);
   assign wdata     = wdata_pad[EW-1:0];

   // Frame words at or above CHANNELS read as zero
   assign rdata_pad = PW'(rdata_ff);
   assign rd_frame  = rdata_pad[PortBits-1:0];

   assign wr_next = (wr_idx_ff == LastIndex) ? '0 : wr_idx_ff + 1'b1;
   assign rd_next = (rd_idx_ff == LastIndex) ? '0 : rd_idx_ff + 1'b1;

   // Frames returned: read limit clipped to the stored count
   assign n_take = (MW'(count_ff) < MW'(read_limit)) ? CountWidth'(count_ff) : read_limit;

   // n never exceeds the count, so one subtract brings each sum into range
   assign drain_sum = {1'b0, rd_idx_ff} + (IW + 1)'(n_take);
   assign peek_sum  = {1'b0, rd_idx_ff} + {1'b0, count_ff - IW'(n_take)};

   assign out_load   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_load;
   assign req_fire   = req_tvalid && req_tready;
   assign consume    = rd_pend_ff && out_load;
   assign issue      = (state_ff == ST_BURST) && (remain_ff != '0) && (!rd_pend_ff || consume);
   assign wr_en      = req_fire && (req_code == REQ_PUSH);

   always_comb begin
      state_in      = state_ff;
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      count_in      = count_ff;
      rd_addr_in    = rd_addr_ff;
      remain_in     = remain_ff;
      nret_in       = nret_ff;
      rd_pend_in    = rd_pend_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_frame_in  = out_frame_ff;
      out_fvalid_in = out_fvalid_ff;
      out_last_in   = out_last_ff;
      out_nret_in   = out_nret_ff;
      out_stored_in = out_stored_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Push: write at the write index, drop the oldest frame on wrap
               if (req_code == REQ_PUSH) begin
                  wr_idx_in = wr_next;
                  if (wr_next == rd_idx_ff) begin
                     rd_idx_in = rd_next;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
               if ((req_code == REQ_DRAIN || req_code == REQ_PEEK) && n_take != '0) begin
                  // Set up the burst; a drain removes its frames right away
                  state_in  = ST_BURST;
                  remain_in = n_take;
                  nret_in   = n_take;
                  if (req_code == REQ_DRAIN) begin
                     rd_addr_in = rd_idx_ff;
                     rd_idx_in  = (drain_sum >= DepthWide) ?
                                  IW'(drain_sum - DepthWide) : IW'(drain_sum);
                     count_in   = count_ff - IW'(n_take);
                  end else begin
                     rd_addr_in = (peek_sum >= DepthWide) ?
                                  IW'(peek_sum - DepthWide) : IW'(peek_sum);
                  end
               end else begin
                  // Push, empty read or unused code: one word with no frame
                  out_valid_in  = 1'b1;
                  out_frame_in  = '0;
                  out_fvalid_in = 1'b0;
                  out_last_in   = 1'b1;
                  out_nret_in   = '0;
                  out_stored_in = CountWidth'(count_in);
               end
            end
         end
         ST_BURST: begin
            if (consume) begin
               out_valid_in  = 1'b1;
               out_frame_in  = rd_frame;
               out_fvalid_in = 1'b1;
               out_last_in   = (remain_ff == '0);
               out_nret_in   = nret_ff;
               out_stored_in = CountWidth'(count_ff);
               rd_pend_in    = 1'b0;
               if (remain_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
            if (issue) begin
               rd_pend_in = 1'b1;
               remain_in  = remain_ff - 1'b1;
               rd_addr_in = (rd_addr_ff == LastIndex) ? '0 : rd_addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Frame memory: one write port for pushes, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx_ff] <= wdata;
      end
      if (issue) begin
         rdata_ff <= mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      nret_ff       <= nret_in;
      out_frame_ff  <= out_frame_in;
      out_fvalid_ff <= out_fvalid_in;
      out_last_ff   <= out_last_in;
      out_nret_ff   <= out_nret_in;
      out_stored_ff <= out_stored_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RspDataWidth - PortBits - 2 * CountWidth)'(0),
                        out_stored_ff, out_nret_ff, out_frame_ff};
   assign rsp_tuser  = out_fvalid_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   // The ring never holds DEPTH frames
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) < DEPTH)
      else $error("stored count reached the ring depth");

   // Index distance matches the stored count
   a_index_count: assert property (@(posedge clock) disable iff (reset)
      ((wr_idx_ff >= rd_idx_ff) ? (int'(wr_idx_ff) - int'(rd_idx_ff))
                                : (int'(wr_idx_ff) + DEPTH - int'(rd_idx_ff)))
      == int'(count_ff))
      else $error("write and read indices disagree with stored count");

   // Memory reads are only outstanding inside a burst
   a_pend_burst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_pend_ff)
      else $error("read outstanding while idle");

   // Loading the final frame ends the burst
   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (consume && remain_ff == '0) |=> (state_ff == ST_IDLE))
      else $error("burst did not end after its final frame");

   // A word without a frame is always the only word of its request
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_fvalid_ff) |-> (out_last_ff && out_nret_ff == '0))
      else $error("frameless result not marked last");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for overwriting_frame_ring_buffer. A frame ring model
// in the scoreboard predicts every response word from the accepted request
// words. Directed requests cover the empty reads, the unused code and the
// field extremes. Random bursts of mixed requests and long push runs follow;
// the push runs wrap the ring and force overwrites. Each idling profile
// gets its own phase: free flow, sparse sender, stalling receiver, both.
// ----------------------------------------------------------------------------
module tb;
   import ofrb_pkg::*;

   localparam int RingDepth = 32;
   localparam int ItemsPerPhase = 40;

   typedef logic [PortChannels-1:0][SampleWidth-1:0] frame_type;

   // one expected response word
   typedef struct packed {
      frame_type             words;
      logic                  frame_valid;
      logic                  is_last;
      logic [CountWidth-1:0] returned;
      logic [CountWidth-1:0] stored;
   } rsp_word_type;

   // -------------------------------------------------------------------------
   // Scoreboard: private copy of the ring plus the queue of pending words
   // -------------------------------------------------------------------------
   class frame_ring_scoreboard;
      frame_type             ring_frames [RingDepth];
      logic [CountWidth-1:0] wr_ptr;
      logic [CountWidth-1:0] rd_ptr;
      int unsigned           held_frames;
      rsp_word_type          pending_words [$];
      int unsigned           errors;

      function new();
         wr_ptr = '0;
         rd_ptr = '0;
         held_frames = 0;
         errors = 0;
      endfunction

      function void push_empty_word();
         rsp_word_type w;
         w = '0;
         w.is_last = 1'b1;
         w.stored = CountWidth'(held_frames);
         pending_words.push_back(w);
      endfunction

      // Work out the response words of one accepted request.
      function void note_request(req_code_type code, frame_type samples,
                                 logic [CountWidth-1:0] read_limit);
         int unsigned           n;
         logic [CountWidth-1:0] first;
         rsp_word_type          w;
         if (code == REQ_PUSH) begin
            ring_frames[wr_ptr] = samples;
            wr_ptr = wr_ptr + 1'b1;
            held_frames++;
            // ring full: drop the oldest frame
            if (wr_ptr == rd_ptr) begin
               rd_ptr = rd_ptr + 1'b1;
               held_frames--;
            end
            push_empty_word();
            return;
         end
         n = (read_limit < held_frames) ? read_limit : held_frames;
         if (code == REQ_NONE || n == 0) begin
            push_empty_word();
            return;
         end
         if (code == REQ_DRAIN) begin
            first = rd_ptr;
            rd_ptr = rd_ptr + CountWidth'(n);
            held_frames -= n;
         end else begin
            first = rd_ptr + CountWidth'(held_frames - n);
         end
         for (int i = 0; i < n; i++) begin
            w.words = ring_frames[first + CountWidth'(i)];
            w.frame_valid = 1'b1;
            w.is_last = (i == n - 1);
            w.returned = CountWidth'(n);
            w.stored = CountWidth'(held_frames);
            pending_words.push_back(w);
         end
      endfunction

      function void report(string field, logic [SampleWidth-1:0] exp_val,
                           logic [SampleWidth-1:0] act_val);
         errors++;
         $display("%0t ns: %s expected %h got %h", $time, field, exp_val, act_val);
      endfunction

      // Compare one accepted response word with the oldest expectation.
      function void check_word(logic [RspDataWidth-1:0] data, logic valid_bit,
                               logic last_bit);
         rsp_word_type exp_w;
         frame_type    got_words;
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected word, expected none got %h", $time, data);
            return;
         end
         exp_w = pending_words.pop_front();
         got_words = data[PortChannels*SampleWidth-1:0];
         for (int c = 0; c < PortChannels; c++)
            if (got_words[c] !== exp_w.words[c])
               report($sformatf("frame_%0d", c), exp_w.words[c], got_words[c]);
         if (valid_bit !== exp_w.frame_valid)
            report("frame_valid", 64'(exp_w.frame_valid), 64'(valid_bit));
         if (last_bit !== exp_w.is_last)
            report("is_last", 64'(exp_w.is_last), 64'(last_bit));
         if (data[260:256] !== exp_w.returned)
            report("returned_count", 64'(exp_w.returned), 64'(data[260:256]));
         if (data[265:261] !== exp_w.stored)
            report("stored_count", 64'(exp_w.stored), 64'(data[265:261]));
      endfunction

      function int pending();
         return pending_words.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, block
   // -------------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic [ReqTypeWidth-1:0] req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [0:0]              rsp_tuser;
   logic                    rsp_tlast;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned counted_items = 0;

   frame_ring_scoreboard sb;

   always #6 clock = ~clock;

   overwriting_frame_ring_buffer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Receiver: stall at random and check every accepted word.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata, rsp_tuser[0], rsp_tlast);
   end

   // -------------------------------------------------------------------------
   // Request driving
   // -------------------------------------------------------------------------
   function automatic frame_type random_frame();
      frame_type f;
      for (int c = 0; c < PortChannels; c++)
         case ($urandom_range(15))
            0: f[c] = '0;
            1: f[c] = '1;
            default: f[c] = {$urandom, $urandom};
         endcase
      return f;
   endfunction

   function automatic logic [CountWidth-1:0] random_read_limit();
      case ($urandom_range(7))
         0: return '0;
         1, 2: return '1;
         default: return CountWidth'($urandom_range(31));
      endcase
   endfunction

   // Offer one request word, hold it until taken, then tell the scoreboard.
   task automatic send_request(req_code_type code, frame_type samples,
                               logic [CountWidth-1:0] read_limit);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= {3'b000, read_limit, samples};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(code, samples, read_limit);
      counted_items++;
   endtask

   // Long push run: always wraps the ring, then read back the whole of it.
   task automatic send_fill_run();
      int unsigned len;
      len = $urandom_range(40, 32);
      for (int i = 0; i < len; i++)
         send_request(REQ_PUSH, random_frame(), random_read_limit());
      send_request(REQ_PEEK, random_frame(), '1);
      send_request(REQ_DRAIN, random_frame(), random_read_limit());
   endtask

   task automatic send_mixed_run();
      int unsigned  len;
      req_code_type code;
      len = $urandom_range(10, 4);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(99)) inside
            [0:47]:  code = REQ_PUSH;
            [48:69]: code = REQ_DRAIN;
            [70:91]: code = REQ_PEEK;
            default: code = REQ_NONE;
         endcase
         send_request(code, random_frame(), random_read_limit());
      end
   endtask

   task automatic run_directed();
      frame_type ones;
      frame_type zeros;
      ones = '1;
      zeros = '0;
      send_request(REQ_DRAIN, zeros, '1);    // empty ring reads
      send_request(REQ_PEEK, ones, '0);
      send_request(REQ_NONE, ones, '1);      // unused code
      send_request(REQ_PUSH, zeros, '0);
      send_request(REQ_PUSH, ones, '1);
      send_request(REQ_PUSH, {4{64'hAAAA_AAAA_AAAA_AAAA}}, 5'd7);
      send_request(REQ_PUSH, {4{64'h5555_5555_5555_5555}}, 5'd24);
      send_request(REQ_PUSH, random_frame(), 5'd3);
      send_request(REQ_PEEK, zeros, '0);     // zero count on a held ring
      send_request(REQ_DRAIN, zeros, '0);
      send_request(REQ_PEEK, zeros, 5'd1);   // newest only
      send_request(REQ_PEEK, zeros, '1);     // clipped to held count
      send_request(REQ_NONE, zeros, 5'd2);
      send_request(REQ_DRAIN, ones, 5'd1);
      send_request(REQ_PEEK, ones, 5'd2);
      send_request(REQ_DRAIN, ones, '1);     // empty the ring
      send_request(REQ_DRAIN, zeros, 5'd5);
      send_request(REQ_PUSH, random_frame(), 5'd16);
      send_request(REQ_DRAIN, zeros, 5'd16);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned phase_goal;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         phase_goal = counted_items + ItemsPerPhase;
         while (counted_items < phase_goal)
            if ($urandom_range(4) == 0) send_fill_run();
            else send_mixed_run();
      end
      req_tvalid <= 1'b0;
      // drain what is still owed, then watch for stray words
      while (sb.pending() != 0) @(posedge clock);
      stall_pct = 0;
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #6_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
